// ===== src/mrsrm_pkg.sv =====
package mrsrm_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 96;

    localparam logic [1:0] MODE_REQUEST  = 2'd0;
    localparam logic [1:0] MODE_INPUT    = 2'd1;
    localparam logic [1:0] MODE_DISCRETE = 2'd2;

    localparam logic [7:0] FC_READ_COILS     = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
    localparam logic [7:0] FC_READ_INPUT     = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
    localparam logic [7:0] FC_WRITE_REG      = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

    localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
    localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;
    localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'd3;
    localparam logic [7:0] EXC_FLAG             = 8'h80;

    localparam logic [15:0] MAX_READ_BITS  = 16'd2000;
    localparam logic [15:0] MAX_READ_REGS  = 16'd125;
    localparam logic [15:0] MAX_WRITE_BITS = 16'd1968;
    localparam logic [15:0] MAX_WRITE_REGS = 16'd123;
    localparam logic [15:0] COIL_ON        = 16'hFF00;
    localparam logic [15:0] HOLDING_RESET  = 16'd25000;
    localparam logic [7:0]  COIL_RESET     = 8'h1F;

    typedef enum logic [1:0] {
        K_BYTE,
        K_BYTE_END,
        K_INPUT,
        K_DISC
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  frame_byte;
        logic [3:0]  update_index;
        logic [15:0] update_value;
        logic [6:0]  discrete_bits;
    } queue_item_t;

    typedef enum logic [1:0] {
        R_EXC,
        R_BITS,
        R_REGS,
        R_ECHO
    } resp_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WR_HI,
        S_WR_LO,
        S_EMIT
    } state_t;

    // Modbus CRC-16, reflected polynomial 0xA001, one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/mrsrm_front.sv =====
module mrsrm_front import mrsrm_pkg::*; #(
    parameter int INPUT_REG_COUNT = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    output logic                 q_valid,
    input  logic                 q_ready,
    output queue_item_t          q_item
);

    queue_item_t fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    queue_item_t item;
    logic        keep;
    logic        push, pop;

    // Classify the incoming transfer; unused modes and out-of-range updates are dropped.
    always_comb begin
        item.frame_byte    = s_tdata[7:0];
        item.update_index  = s_tdata[11:8];
        item.update_value  = s_tdata[27:12];
        item.discrete_bits = s_tdata[34:28];
        item.kind          = K_BYTE;
        keep               = 1'b0;
        case (s_tuser)
            MODE_REQUEST: begin
                item.kind = s_tlast ? K_BYTE_END : K_BYTE;
                keep      = 1'b1;
            end
            MODE_INPUT: begin
                item.kind = K_INPUT;
                keep      = ({1'b0, s_tdata[11:8]} < 5'(INPUT_REG_COUNT));
            end
            MODE_DISCRETE: begin
                item.kind = K_DISC;
                keep      = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready && keep;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== src/mrsrm_back.sv =====
module mrsrm_back import mrsrm_pkg::*; #(
    parameter int HOLDING_COUNT   = 3,
    parameter int INPUT_REG_COUNT = 9,
    parameter int COIL_COUNT      = 6,
    parameter int DISCRETE_COUNT  = 7,
    parameter int FRAME_BYTES     = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  queue_item_t          q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int IW  = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int LW  = $clog2(FRAME_BYTES + 1);
    localparam int HW  = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int RW  = (INPUT_REG_COUNT > 1) ? $clog2(INPUT_REG_COUNT) : 1;
    localparam logic [7:0] COIL_MASK = 8'((9'h1 << COIL_COUNT) - 9'h1);
    localparam logic [7:0] DISC_MASK = 8'((9'h1 << DISCRETE_COUNT) - 9'h1);

    state_t      state_reg, state_next;
    logic [7:0]  buf_reg [FRAME_BYTES];
    logic [LW-1:0] len_reg, len_next;
    logic [15:0] hold_reg [HOLDING_COUNT];
    logic [15:0] inp_reg [INPUT_REG_COUNT];
    logic [7:0]  coil_reg, coil_next;
    logic [7:0]  disc_reg, disc_next;
    logic [15:0] good_reg, good_next;
    logic [15:0] bad_reg, bad_next;
    logic [7:0]  addr_reg;
    resp_kind_t  kind_reg, kind_next;
    logic [7:0]  code_reg, code_next;
    logic [5:0]  n_reg, n_next;
    logic [5:0]  k_reg, k_next;
    logic [15:0] crc_reg, crc_next;
    logic [3:0]  i_reg, i_next;
    logic [7:0]  hi_reg;
    logic        out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic        out_last_reg;

    logic [7:0]  rx [8];
    logic [7:0]  fc;
    logic [15:0] start, cnt;
    logic [16:0] last;
    logic [7:0]  rd_addr;
    logic [7:0]  rd_byte;
    logic        out_load;
    logic [7:0]  tx_byte;
    logic [7:0]  src8, bits8;
    logic [5:0]  reg_off;
    logic [4:0]  reg_idx;
    logic [15:0] reg_val;
    logic [15:0] hold_pad [3];
    logic        wr_hold_dec, wr_hold_seq;
    logic [HW-1:0] wr_hold_idx;

    // Fixed taps on the request header; bytes not received read as zero.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            rx[j] = (LW'(j) < len_reg) ? buf_reg[IW'(j)] : 8'h00;
        end
    end

    assign fc    = rx[1];
    assign start = {rx[2], rx[3]};
    assign cnt   = {rx[4], rx[5]};
    assign last  = {1'b0, start} + {1'b0, cnt} - 17'd1;

    // One variable read for the write-multiple-registers data.
    assign rd_addr = (state_reg == S_WR_HI) ? (8'd7 + {3'd0, i_reg, 1'b0})
                                            : (8'd8 + {3'd0, i_reg, 1'b0});
    assign rd_byte = ({1'b0, rd_addr} < 9'(len_reg)) ? buf_reg[rd_addr[IW-1:0]] : 8'h00;

    assign q_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || m_tready);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            hold_pad[j] = (j < HOLDING_COUNT) ? hold_reg[HW'(j)] : 16'h0000;
        end
    end

    // Response byte at position k.
    always_comb begin
        src8    = (fc == FC_READ_COILS) ? coil_reg : disc_reg;
        bits8   = 8'((src8 >> start[2:0]) & 8'((9'h1 << cnt[3:0]) - 9'h1));
        reg_off = (k_reg - 6'd3) >> 1;
        reg_idx = 5'(start[3:0]) + 5'(reg_off);
        if (fc == FC_READ_HOLDING) begin
            reg_val = ({1'b0, reg_idx} < 6'(HOLDING_COUNT)) ? hold_reg[reg_idx[HW-1:0]] : 16'h0;
        end else begin
            reg_val = ({1'b0, reg_idx} < 6'(INPUT_REG_COUNT)) ? inp_reg[reg_idx[RW-1:0]] : 16'h0;
        end
        tx_byte = 8'h00;
        case (kind_reg)
            R_EXC: begin
                case (k_reg)
                    6'd0:    tx_byte = rx[0];
                    6'd1:    tx_byte = rx[1] | EXC_FLAG;
                    default: tx_byte = code_reg;
                endcase
            end
            R_BITS: begin
                case (k_reg)
                    6'd0:    tx_byte = addr_reg;
                    6'd1:    tx_byte = fc;
                    6'd2:    tx_byte = 8'((cnt + 16'd7) >> 3);
                    default: tx_byte = bits8;
                endcase
            end
            R_REGS: begin
                case (k_reg)
                    6'd0:    tx_byte = addr_reg;
                    6'd1:    tx_byte = fc;
                    6'd2:    tx_byte = {cnt[6:0], 1'b0};
                    default: tx_byte = (k_reg[0]) ? reg_val[15:8] : reg_val[7:0];
                endcase
            end
            default: begin
                case (k_reg)
                    6'd0:    tx_byte = addr_reg;
                    6'd1:    tx_byte = rx[1];
                    6'd2:    tx_byte = rx[2];
                    6'd3:    tx_byte = rx[3];
                    6'd4:    tx_byte = rx[4];
                    default: tx_byte = rx[5];
                endcase
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid && q_item.kind == K_BYTE_END) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (fc == FC_WRITE_REGS && cnt != 16'd0 && cnt <= MAX_WRITE_REGS
                        && last < 17'(HOLDING_COUNT)) begin
                    state_next = S_WR_HI;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_WR_HI: state_next = S_WR_LO;
            S_WR_LO: state_next = ({12'd0, i_reg} == cnt - 16'd1) ? S_EMIT : S_WR_HI;
            S_EMIT: begin
                if (out_load && k_reg == n_reg + 6'd1) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        len_next    = len_reg;
        coil_next   = coil_reg;
        disc_next   = disc_reg;
        good_next   = good_reg;
        bad_next    = bad_reg;
        kind_next   = kind_reg;
        code_next   = code_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        crc_next    = crc_reg;
        i_next      = i_reg;
        wr_hold_dec = 1'b0;
        wr_hold_seq = 1'b0;
        wr_hold_idx = start[HW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    case (q_item.kind)
                        K_BYTE, K_BYTE_END: begin
                            if (len_reg < LW'(FRAME_BYTES)) begin
                                len_next = len_reg + LW'(1);
                            end
                        end
                        K_DISC:  disc_next = {1'b0, q_item.discrete_bits} & DISC_MASK;
                        default: disc_next = disc_reg;
                    endcase
                end
            end
            S_DECODE: begin
                kind_next = R_EXC;
                n_next    = 6'd3;
                code_next = EXC_ILLEGAL_FUNCTION;
                k_next    = 6'd0;
                crc_next  = 16'hFFFF;
                i_next    = 4'd0;
                case (fc)
                    FC_READ_COILS, FC_READ_DISCRETE: begin
                        if (cnt == 16'd0 || cnt > MAX_READ_BITS) begin
                            code_next = EXC_ILLEGAL_VALUE;
                        end else if (last >= ((fc == FC_READ_COILS) ? 17'(COIL_COUNT)
                                                                    : 17'(DISCRETE_COUNT))) begin
                            code_next = EXC_ILLEGAL_ADDRESS;
                        end else begin
                            kind_next = R_BITS;
                            n_next    = 6'd4;
                        end
                    end
                    FC_READ_HOLDING, FC_READ_INPUT: begin
                        if (cnt == 16'd0 || cnt > MAX_READ_REGS) begin
                            code_next = EXC_ILLEGAL_VALUE;
                        end else if (last >= ((fc == FC_READ_HOLDING) ? 17'(HOLDING_COUNT)
                                                                      : 17'(INPUT_REG_COUNT))) begin
                            code_next = EXC_ILLEGAL_ADDRESS;
                        end else begin
                            kind_next = R_REGS;
                            n_next    = 6'd3 + {cnt[4:0], 1'b0};
                        end
                    end
                    FC_WRITE_COIL: begin
                        if (start >= 16'(COIL_COUNT)) begin
                            code_next = EXC_ILLEGAL_ADDRESS;
                        end else begin
                            kind_next = R_ECHO;
                            n_next    = 6'd6;
                            if (cnt == COIL_ON) begin
                                coil_next = (coil_reg | (8'h1 << start[2:0])) & COIL_MASK;
                            end else if (cnt == 16'd0) begin
                                coil_next = coil_reg & ~(8'h1 << start[2:0]) & COIL_MASK;
                            end
                        end
                    end
                    FC_WRITE_REG: begin
                        if (start >= 16'(HOLDING_COUNT)) begin
                            code_next = EXC_ILLEGAL_ADDRESS;
                        end else begin
                            kind_next   = R_ECHO;
                            n_next      = 6'd6;
                            wr_hold_dec = 1'b1;
                        end
                    end
                    FC_WRITE_COILS: begin
                        if (cnt == 16'd0 || cnt > MAX_WRITE_BITS) begin
                            code_next = EXC_ILLEGAL_VALUE;
                        end else if (last >= 17'(COIL_COUNT)) begin
                            code_next = EXC_ILLEGAL_ADDRESS;
                        end else begin
                            kind_next = R_ECHO;
                            n_next    = 6'd6;
                            for (int j = 0; j < COIL_COUNT; j++) begin
                                if (16'(j) >= start && 17'(j) <= last) begin
                                    coil_next[j] = rx[7][3'(16'(j) - start)];
                                end
                            end
                        end
                    end
                    FC_WRITE_REGS: begin
                        if (cnt == 16'd0 || cnt > MAX_WRITE_REGS) begin
                            code_next = EXC_ILLEGAL_VALUE;
                        end else if (last >= 17'(HOLDING_COUNT)) begin
                            code_next = EXC_ILLEGAL_ADDRESS;
                        end else begin
                            kind_next = R_ECHO;
                            n_next    = 6'd6;
                        end
                    end
                    default: code_next = EXC_ILLEGAL_FUNCTION;
                endcase
                if (kind_next == R_EXC) begin
                    bad_next = bad_reg + 16'd1;
                end else begin
                    good_next = good_reg + 16'd1;
                end
            end
            S_WR_LO: begin
                wr_hold_seq = 1'b1;
                wr_hold_idx = HW'(5'(start[3:0]) + 5'(i_reg));
                i_next      = i_reg + 4'd1;
            end
            S_EMIT: begin
                if (out_load) begin
                    k_next = k_reg + 6'd1;
                    if (k_reg < n_reg) begin
                        crc_next = crc_byte(crc_reg, tx_byte);
                    end
                    if (k_reg == n_reg + 6'd1) begin
                        len_next = '0;
                    end
                end
            end
            default: k_next = k_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            coil_reg      <= COIL_RESET & COIL_MASK;
            disc_reg      <= 8'h00;
            good_reg      <= 16'd0;
            bad_reg       <= 16'd0;
            addr_reg      <= 8'd1;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < HOLDING_COUNT; j++) begin
                hold_reg[j] <= (j < 2) ? HOLDING_RESET : 16'h0000;
            end
            for (int j = 0; j < INPUT_REG_COUNT; j++) begin
                inp_reg[j] <= 16'h0000;
            end
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            coil_reg  <= coil_next;
            disc_reg  <= disc_next;
            good_reg  <= good_next;
            bad_reg   <= bad_next;
            if (cfg_wr_en) begin
                addr_reg <= cfg_wr_data;
            end
            if (wr_hold_dec) begin
                hold_reg[wr_hold_idx] <= cnt;
            end else if (wr_hold_seq) begin
                hold_reg[wr_hold_idx] <= {hi_reg, rd_byte};
            end
            if (state_reg == S_IDLE && q_valid && q_item.kind == K_INPUT) begin
                inp_reg[q_item.update_index[RW-1:0]] <= q_item.update_value;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        code_reg <= code_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        crc_reg  <= crc_next;
        i_reg    <= i_next;
        if (state_reg == S_WR_HI) begin
            hi_reg <= rd_byte;
        end
        if (state_reg == S_IDLE && q_valid && len_reg < LW'(FRAME_BYTES)
                && (q_item.kind == K_BYTE || q_item.kind == K_BYTE_END)) begin
            buf_reg[len_reg[IW-1:0]] <= q_item.frame_byte;
        end
        if (out_load) begin
            out_last_reg <= (k_reg == n_reg + 6'd1);
            out_data_reg <= {2'b00, bad_reg, good_reg, hold_pad[2], hold_pad[1], hold_pad[0],
                             coil_reg[5:0],
                             (k_reg < n_reg) ? tx_byte
                                 : (k_reg == n_reg) ? crc_reg[7:0] : crc_reg[15:8]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/modbus_rtu_slave_register_map_unit.sv =====
// Modbus RTU slave register map.
// The slave-side stream carries one item per transfer. s_tuser selects the kind:
// a request byte (s_tlast marks the last byte of a frame), an input register
// update, or a discrete input update. Items pass through a two-entry queue to a
// sequencer that buffers the frame, serves it at its last byte and emits the
// response, one byte per master-side transfer, with the CRC appended low byte
// first and m_tlast on the final byte. Each response byte also carries the coil
// states, holding registers 0 to 2 and the success and error counters.
// The sequencer takes a request byte or an update while idle. A closed frame is
// decoded, the holding registers of a write-multiple request are written, then
// the response (5 to 23 bytes) goes out one byte per cycle while unstalled.
// The single sequencer sets the rate: one item is worked at a time.
// Reset (aresetn low, synchronous) empties the queue, clears the frame buffer
// and counters, loads holding registers 0 and 1 with 25000 and the coils with
// 0x1F, and sets the station address to 1. When the receiver stalls, the
// output register holds its byte and the sequencer waits; the queue keeps
// accepting until it is full, then s_tready falls. The user writes the station
// address via cfg_wr_en/cfg_wr_data only while idle; the block does not check it.
module modbus_rtu_slave_register_map_unit import mrsrm_pkg::*; #(
    parameter int HOLDING_COUNT   = 3,
    parameter int INPUT_REG_COUNT = 9,
    parameter int COIL_COUNT      = 6,
    parameter int DISCRETE_COUNT  = 7,
    parameter int FRAME_BYTES     = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // frame_byte[7:0], update_index[11:8], update_value[27:12],
    // discrete_bits[34:28], zero fill above.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode[1:0].
    input  logic [1:0]           s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // reply_byte[7:0], coil_states[13:8], pwm_red[29:14], pwm_green[45:30],
    // pwm_blue[61:46], good_requests[77:62], bad_requests[93:78], zero fill above.
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic        q_valid;
    logic        q_ready;
    queue_item_t q_item;

    mrsrm_front #(
        .INPUT_REG_COUNT(INPUT_REG_COUNT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    mrsrm_back #(
        .HOLDING_COUNT  (HOLDING_COUNT),
        .INPUT_REG_COUNT(INPUT_REG_COUNT),
        .COIL_COUNT     (COIL_COUNT),
        .DISCRETE_COUNT (DISCRETE_COUNT),
        .FRAME_BYTES    (FRAME_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== tb/tb.sv =====
module tb;
    import mrsrm_pkg::*;

    // One transfer toward the slave side of the register map.
    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  fbyte;
        logic        fend;
        logic [3:0]  idx;
        logic [15:0] val;
        logic [6:0]  disc;
        logic [7:0]  exc;   // exception code typed in for a directed frame end, 0 if none
    } stim_t;

    // One response byte with the status snapshot that travels beside it.
    typedef struct packed {
        logic [7:0]  rbyte;
        logic        rlast;
        logic [5:0]  coils;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] good;
        logic [15:0] bad;
    } reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [7:0]           cfg_wr_data = 8'd0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = MODE_REQUEST;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    modbus_rtu_slave_register_map_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the register map, updated as each transfer is accepted.
    logic [7:0]  station;
    logic [7:0]  frame_buf [32];
    int          frame_len;
    logic [15:0] hold_regs [3];
    logic [15:0] input_regs [9];
    logic [5:0]  coil_bits;
    logic [6:0]  disc_bits;
    logic [15:0] good_count;
    logic [15:0] bad_count;
    logic [7:0]  last_code;   // third byte of the most recent predicted response

    reply_t      pending_replies [$];
    int          mismatches = 0;
    int          items_sent = 0;
    bit          sender_fast = 0;
    stim_t       directed [$];

    function automatic logic [31:0] frame_at(int i);
        return (i < frame_len && i < 32) ? {24'd0, frame_buf[i]} : 32'd0;
    endfunction

    // Serve a closed frame the way the slave does and queue every response byte.
    task automatic serve_frame();
        logic [7:0]  tx [48];
        logic [31:0] fc, start, cnt, lastad, nlim, src, bitv, a;
        logic [15:0] v, crc;
        logic [7:0]  exc;
        int          n;
        reply_t      r;
        fc = frame_at(1);
        start = (frame_at(2) << 8) | frame_at(3);
        cnt = (frame_at(4) << 8) | frame_at(5);
        lastad = start + cnt - 1;
        exc = 8'd0;
        n = 0;
        case (fc[7:0] == fc ? fc[7:0] : 8'hFF)
            FC_READ_COILS, FC_READ_DISCRETE: begin
                nlim = (fc == FC_READ_COILS) ? 6 : 7;
                src = (fc == FC_READ_COILS) ? {26'd0, coil_bits} : {25'd0, disc_bits};
                if (cnt < 1 || cnt > MAX_READ_BITS) exc = EXC_ILLEGAL_VALUE;
                else if (lastad > nlim - 1) exc = EXC_ILLEGAL_ADDRESS;
                else begin
                    tx[0] = station;
                    tx[1] = fc[7:0];
                    tx[2] = 8'((cnt + 7) / 8);
                    tx[3] = 8'((src >> start) & ((32'd1 << cnt) - 1));
                    n = 4;
                end
            end
            FC_READ_HOLDING, FC_READ_INPUT: begin
                nlim = (fc == FC_READ_HOLDING) ? 3 : 9;
                if (cnt < 1 || cnt > MAX_READ_REGS) exc = EXC_ILLEGAL_VALUE;
                else if (lastad > nlim - 1) exc = EXC_ILLEGAL_ADDRESS;
                else begin
                    tx[0] = station;
                    tx[1] = fc[7:0];
                    tx[2] = 8'(cnt * 2);
                    n = 3;
                    for (int i = 0; i < cnt; i++) begin
                        a = start + i;
                        v = (fc == FC_READ_HOLDING) ? hold_regs[a] : input_regs[a];
                        tx[n] = v[15:8];
                        tx[n+1] = v[7:0];
                        n += 2;
                    end
                end
            end
            FC_WRITE_COIL: begin
                if (start > 5) exc = EXC_ILLEGAL_ADDRESS;
                else if (cnt == COIL_ON) coil_bits[start] = 1'b1;
                else if (cnt == 0) coil_bits[start] = 1'b0;
            end
            FC_WRITE_REG: begin
                if (start > 2) exc = EXC_ILLEGAL_ADDRESS;
                else hold_regs[start] = cnt[15:0];
            end
            FC_WRITE_COILS: begin
                if (cnt < 1 || cnt > MAX_WRITE_BITS) exc = EXC_ILLEGAL_VALUE;
                else if (lastad > 5) exc = EXC_ILLEGAL_ADDRESS;
                else
                    for (int i = 0; i < cnt; i++) begin
                        bitv = (frame_at(7 + i / 8) >> (i % 8)) & 1;
                        coil_bits[start + i] = bitv[0];
                    end
            end
            FC_WRITE_REGS: begin
                if (cnt < 1 || cnt > MAX_WRITE_REGS) exc = EXC_ILLEGAL_VALUE;
                else if (lastad > 2) exc = EXC_ILLEGAL_ADDRESS;
                else
                    for (int i = 0; i < cnt; i++)
                        hold_regs[start + i] = 16'((frame_at(7 + 2 * i) << 8)
                                                   | frame_at(8 + 2 * i));
            end
            default: exc = EXC_ILLEGAL_FUNCTION;
        endcase
        if (exc != 0) begin
            tx[0] = 8'(frame_at(0));
            tx[1] = 8'(frame_at(1)) | EXC_FLAG;
            tx[2] = exc;
            n = 3;
            bad_count++;
        end else begin
            // Writes answer with the station address, then request bytes 1 to 5.
            if (n == 0) begin
                tx[0] = station;
                for (int i = 1; i < 6; i++) tx[i] = 8'(frame_at(i));
                n = 6;
            end
            good_count++;
        end
        last_code = tx[2];
        crc = 16'hFFFF;
        for (int i = 0; i < n; i++) begin
            crc ^= {8'd0, tx[i]};
            for (int b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
        end
        tx[n] = crc[7:0];
        tx[n+1] = crc[15:8];
        n += 2;
        for (int k = 0; k < n; k++) begin
            r.rbyte = tx[k];
            r.rlast = (k == n - 1);
            r.coils = coil_bits;
            r.red = hold_regs[0];
            r.green = hold_regs[1];
            r.blue = hold_regs[2];
            r.good = good_count;
            r.bad = bad_count;
            pending_replies.push_back(r);
        end
        frame_len = 0;
    endtask

    task automatic apply_item(stim_t it);
        if (it.mode == MODE_INPUT) begin
            if (it.idx < 9) input_regs[it.idx] = it.val;
        end else if (it.mode == MODE_DISCRETE) begin
            disc_bits = it.disc;
        end else if (it.mode == MODE_REQUEST) begin
            if (frame_len < 32) begin
                frame_buf[frame_len] = it.fbyte;
                frame_len++;
            end
            if (it.fend) serve_frame();
        end
    endtask

    // Drive one transfer after an optional gap and wait for it to be taken.
    task automatic send_item(stim_t it);
        int gap;
        gap = sender_fast ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tlast <= it.fend;
        s_tdata <= {5'd0, it.disc, it.val, it.idx, it.fbyte};
        do @(posedge aclk); while (!s_tready);
        apply_item(it);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b, logic fin);
        stim_t it;
        it = '{MODE_REQUEST, b, fin, 4'($urandom), 16'($urandom), 7'($urandom), 8'd0};
        send_item(it);
    endtask

    // Well-formed request with random content, sometimes cut short or overlong.
    task automatic random_frame();
        logic [7:0]  bytes [40];
        logic [15:0] start, cnt;
        logic [7:0]  fc;
        int          len, nd, pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: fc = FC_READ_COILS;
            1: fc = FC_READ_DISCRETE;
            2: fc = FC_READ_HOLDING;
            3: fc = FC_READ_INPUT;
            4: fc = FC_WRITE_COIL;
            5: fc = FC_WRITE_REG;
            6: fc = FC_WRITE_COILS;
            7: fc = FC_WRITE_REGS;
            8: fc = FC_WRITE_REGS;
            default: fc = 8'($urandom);
        endcase
        start = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
        case ($urandom_range(0, 9))
            0: cnt = 16'($urandom);
            1: begin
                case ($urandom_range(0, 7))
                    0: cnt = MAX_READ_REGS;
                    1: cnt = MAX_READ_REGS + 1;
                    2: cnt = MAX_READ_BITS;
                    3: cnt = MAX_READ_BITS + 1;
                    4: cnt = MAX_WRITE_REGS;
                    5: cnt = MAX_WRITE_REGS + 1;
                    6: cnt = MAX_WRITE_BITS;
                    default: cnt = MAX_WRITE_BITS + 1;
                endcase
            end
            default: cnt = 16'($urandom_range(0, 9));
        endcase
        if (fc == FC_WRITE_COIL)
            case ($urandom_range(0, 2))
                0: cnt = COIL_ON;
                1: cnt = 16'd0;
                default: cnt = 16'($urandom);
            endcase
        if (fc == FC_WRITE_REG) cnt = 16'($urandom);
        bytes[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : station;
        bytes[1] = fc;
        bytes[2] = start[15:8];
        bytes[3] = start[7:0];
        bytes[4] = cnt[15:8];
        bytes[5] = cnt[7:0];
        len = 6;
        if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
            nd = (fc == FC_WRITE_COILS) ? (cnt + 7) / 8 : cnt * 2;
            if (nd > 24) nd = 24;
            bytes[6] = 8'(nd);
            len = 7 + nd;
            for (int i = 7; i < len; i++) bytes[i] = 8'($urandom);
        end
        // Trailing CRC is never checked by the slave, so it is random here.
        bytes[len] = 8'($urandom);
        bytes[len+1] = 8'($urandom);
        len += 2;
        pick = $urandom_range(0, 19);
        if (pick < 2) len = $urandom_range(1, len);
        else if (pick == 2) begin
            for (int i = len; i < 36; i++) bytes[i] = 8'($urandom);
            len = 36;
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) random_update();
            send_byte(bytes[i], i == len - 1);
        end
    endtask

    task automatic random_update();
        stim_t it;
        it = '{2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom), 4'($urandom),
               16'($urandom), 7'($urandom), 8'd0};
        send_item(it);
    endtask

    // Wait for every outstanding response byte, then let the slave settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    task automatic write_station(logic [7:0] a);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        station = a;
    endtask

    // Receiver: random stalls, with runs of no stalling, and field-by-field checks.
    initial begin
        int     stall;
        bit     rx_fast;
        reply_t e;
        reply_t got;
        rx_fast = 0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
            stall = rx_fast ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.rbyte = m_tdata[7:0];
            got.rlast = m_tlast;
            got.coils = m_tdata[13:8];
            got.red = m_tdata[29:14];
            got.green = m_tdata[45:30];
            got.blue = m_tdata[61:46];
            got.good = m_tdata[77:62];
            got.bad = m_tdata[93:78];
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response byte %h", got.rbyte);
            end else begin
                e = pending_replies.pop_front();
                if (got != e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp byte %h last %b coils %h hr %h %h %h cnt %h %h",
                                 e.rbyte, e.rlast, e.coils, e.red, e.green, e.blue,
                                 e.good, e.bad, "\n         got byte %h last %b coils %h",
                                 got.rbyte, got.rlast, got.coils,
                                 " hr %h %h %h cnt %h %h",
                                 got.red, got.green, got.blue, got.good, got.bad);
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        station = 8'd1;
        frame_len = 0;
        hold_regs = '{HOLDING_RESET, HOLDING_RESET, 16'd0};
        foreach (input_regs[i]) input_regs[i] = 16'd0;
        coil_bits = COIL_RESET[5:0];
        disc_bits = 7'd0;
        good_count = 16'd0;
        bad_count = 16'd0;

        // Directed frames; exception codes that follow directly from the request
        // are typed in, the rest is left to the shadow model.
        directed.push_back('{MODE_REQUEST, 8'h01, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, FC_READ_COILS, 1'b1, 4'h0, 16'h0000, 7'h00,
                             EXC_ILLEGAL_VALUE});
        directed.push_back('{MODE_REQUEST, 8'hFF, 1'b0, 4'hF, 16'hFFFF, 7'h7F, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h07, 1'b1, 4'h0, 16'h0000, 7'h00,
                             EXC_ILLEGAL_FUNCTION});
        directed.push_back('{MODE_REQUEST, 8'h01, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, FC_WRITE_COIL, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h00, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h06, 1'b1, 4'h0, 16'h0000, 7'h00,
                             EXC_ILLEGAL_ADDRESS});
        directed.push_back('{MODE_DISCRETE, 8'h00, 1'b0, 4'h0, 16'h0000, 7'h7F, 8'd0});
        directed.push_back('{MODE_INPUT, 8'h00, 1'b0, 4'h8, 16'hFFFF, 7'h00, 8'd0});
        directed.push_back('{MODE_INPUT, 8'h00, 1'b0, 4'hF, 16'h1234, 7'h00, 8'd0});
        directed.push_back('{2'd3, 8'hFF, 1'b1, 4'h0, 16'h0000, 7'h00, 8'd0});
        // Read all seven discrete inputs, then input registers 8 and 9 (one past the end).
        directed.push_back('{MODE_REQUEST, 8'h01, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, FC_READ_DISCRETE, 1'b0, 4'h0, 16'h0, 7'h0, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h00, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h00, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h00, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h07, 1'b1, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h01, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, FC_READ_INPUT, 1'b0, 4'h0, 16'h0, 7'h0, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h00, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h08, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h00, 1'b0, 4'h0, 16'h0000, 7'h00, 8'd0});
        directed.push_back('{MODE_REQUEST, 8'h02, 1'b1, 4'h0, 16'h0000, 7'h00,
                             EXC_ILLEGAL_ADDRESS});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_item(directed[i]);
            if (directed[i].exc != 0 && last_code != directed[i].exc) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: exception %0d predicted, %0d typed",
                             i, last_code, directed[i].exc);
            end
        end
        drain();

        // Three phases at different station addresses, extremes first.
        for (int ph = 0; ph < 3; ph++) begin
            write_station(ph == 0 ? 8'd247 : ph == 1 ? 8'd1 : 8'($urandom_range(2, 246)));
            while (items_sent < 24 + 50 * (ph + 1)) begin
                if ($urandom_range(0, 3) == 0) sender_fast = !sender_fast;
                if ($urandom_range(0, 5) == 0) random_update();
                random_frame();
            end
            drain();
        end

        if (mismatches == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end
endmodule
